/* rtl/lss_pkg.sv */
// Shared types, codes and widths of the LED scene position stepper.
package lss_pkg;

    localparam int GROUPS_DEF  = 8;
    localparam int ELAPSED_W   = 16;
    localparam int POS_OUT_W   = 11;
    localparam int MODE_W      = 2;
    localparam int SPEED_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int INTERVAL_W  = 9;
    localparam int DIV_W       = ELAPSED_W + 8;
    localparam int CNT_W       = $clog2(DIV_W);

    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 1'd1;

    localparam logic [MODE_W-1:0] MODE_STATIC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHASE_LR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHASE_RL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PING_PONG = 2'd3;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 9'd320;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_APPLY
    } t_state;

endpackage

/* rtl/lss_in_if.sv */
// Input channel carrying the elapsed time of one tick.
interface lss_in_if;
    logic                           valid;
    logic                           ready;
    logic [lss_pkg::ELAPSED_W-1:0]  elapsed_time;

    modport source (output valid, output elapsed_time, input ready);
    modport sink (input valid, input elapsed_time, output ready);
endinterface

/* rtl/lss_out_if.sv */
// Output channel carrying the light position and direction after one tick.
interface lss_out_if;
    logic                           valid;
    logic                           ready;
    logic [lss_pkg::POS_OUT_W-1:0]  position;
    logic                           moving_up;

    modport source (output valid, output position, output moving_up, input ready);
    modport sink (input valid, input position, input moving_up, output ready);
endinterface

/* rtl/led_scene_position_stepper.sv */
// Top level of the LED scene position stepper with its bit-serial step divider.
//
// Each input transaction is one tick of elapsed milliseconds; each tick produces exactly one
// output transaction with the Q8 light position and the ping-pong direction after the tick.
// A moving tick is accepted, then the restoring divider forms round(256 * elapsed / interval)
// one quotient bit per cycle (the step modulo the span is built from the same bits), and then
// the position is updated. A tick with zero elapsed time or in static mode skips the divider.
// The update waits while an unaccepted result holds the output register. A new tick is
// accepted while the previous result still waits in the output register. The interval is
// recomputed when speed is written; writing scene_mode restarts the scene.
module led_scene_position_stepper #(
    parameter int GROUPS = lss_pkg::GROUPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lss_in_if.sink                          i_in,
    lss_out_if.source                       o_out
);

    localparam int SPAN    = GROUPS * 256;
    localparam int MAX_POS = (GROUPS - 1) * 256;
    localparam int POS_W   = $clog2(SPAN);
    localparam int DIV_W   = lss_pkg::DIV_W;
    localparam int REM_W   = lss_pkg::INTERVAL_W;
    localparam int IV_W    = lss_pkg::INTERVAL_W;

    // Interval in ms for a speed setting; the division by 255 uses a reciprocal estimate
    // that is at most one low, followed by one correction.
    function automatic logic [IV_W-1:0] interval_of(input logic [lss_pkg::SPEED_W-1:0] s);
        logic [16:0] x;
        logic [16:0] q0;
        logic [16:0] r;
        begin
            x  = 17'(8'd255 - s) * 17'd280;
            q0 = (x + (x >> 8)) >> 8;
            r  = x - q0 * 17'd255;
            if (r >= 17'd255) begin
                q0 = q0 + 17'd1;
            end
            interval_of = IV_W'(q0 + 17'd40);
        end
    endfunction

    lss_pkg::t_state r_state;
    lss_pkg::t_state n_state;

    logic [lss_pkg::MODE_W-1:0]     r_mode;
    logic [IV_W-1:0]                r_interval;
    logic [POS_W-1:0]               r_pos;
    logic                           r_dir;
    logic                           r_skip;
    logic [DIV_W-1:0]               r_work;
    logic [REM_W-1:0]               r_rem;
    logic [POS_W-1:0]               r_smod;
    logic [lss_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_ovalid;
    logic [lss_pkg::POS_OUT_W-1:0]  r_opos;
    logic                           r_odir;

    logic [POS_W-1:0]  n_pos;
    logic              n_dir;
    logic              w_in_ready;
    logic              w_load;
    logic              w_accept;
    logic              w_div_last;
    logic [REM_W:0]    w_trial;
    logic              w_qbit;
    logic [POS_W:0]    w_mod_trial;
    logic              w_step_zero;
    logic [DIV_W-1:0]  w_step;
    logic [POS_W-1:0]  w_smod;
    logic [DIV_W:0]    w_up_sum;
    logic [POS_W:0]    w_fwd;
    logic [POS_W:0]    w_back;

    assign w_accept   = i_in.valid && w_in_ready;
    assign w_div_last = (r_cnt == lss_pkg::CNT_W'(DIV_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            lss_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if ((i_in.elapsed_time == '0) || (r_mode == lss_pkg::MODE_STATIC)) begin
                        n_state = lss_pkg::ST_APPLY;
                    end else begin
                        n_state = lss_pkg::ST_DIV;
                    end
                end
            end
            lss_pkg::ST_DIV: begin
                if (w_div_last) begin
                    n_state = lss_pkg::ST_APPLY;
                end
            end
            lss_pkg::ST_APPLY: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = lss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            lss_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            lss_pkg::ST_APPLY: begin
                w_load = !r_ovalid || o_out.ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // One restoring division step, plus the running step modulo the span.
    always_comb begin
        w_trial     = {r_rem, r_work[DIV_W-1]};
        w_qbit      = (w_trial >= {1'b0, r_interval});
        w_mod_trial = {r_smod, w_qbit};
        if (w_mod_trial >= (POS_W + 1)'(SPAN)) begin
            w_mod_trial = w_mod_trial - (POS_W + 1)'(SPAN);
        end
    end

    always_comb begin
        w_step_zero = (r_work == '0);
        w_step      = w_step_zero ? DIV_W'(1) : r_work;
        w_smod      = w_step_zero ? POS_W'(1) : r_smod;
        w_up_sum    = {1'b0, w_step} + (DIV_W + 1)'(r_pos);
        w_fwd       = {1'b0, r_pos} + {1'b0, w_smod};
        if (w_fwd >= (POS_W + 1)'(SPAN)) begin
            w_fwd = w_fwd - (POS_W + 1)'(SPAN);
        end
        if (r_pos >= w_smod) begin
            w_back = {1'b0, r_pos} - {1'b0, w_smod};
        end else begin
            w_back = {1'b0, r_pos} + (POS_W + 1)'(SPAN) - {1'b0, w_smod};
        end
        n_pos = r_pos;
        n_dir = r_dir;
        if (!r_skip) begin
            case (r_mode)
                lss_pkg::MODE_CHASE_LR: begin
                    n_pos = POS_W'(w_fwd);
                end
                lss_pkg::MODE_CHASE_RL: begin
                    n_pos = POS_W'(w_back);
                end
                lss_pkg::MODE_PING_PONG: begin
                    if (r_dir) begin
                        if (w_up_sum >= (DIV_W + 1)'(MAX_POS)) begin
                            n_pos = POS_W'(MAX_POS);
                            n_dir = 1'b0;
                        end else begin
                            n_pos = POS_W'(w_up_sum);
                        end
                    end else begin
                        if (DIV_W'(r_pos) <= w_step) begin
                            n_pos = '0;
                            n_dir = 1'b1;
                        end else begin
                            n_pos = r_pos - POS_W'(w_step);
                        end
                    end
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lss_pkg::ST_IDLE;
            r_mode     <= lss_pkg::MODE_STATIC;
            r_interval <= lss_pkg::INTERVAL_RESET;
            r_pos      <= '0;
            r_dir      <= 1'b1;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_pos    <= n_pos;
                r_dir    <= n_dir;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lss_pkg::CFG_SCENE_MODE: begin
                        r_mode <= i_cfg_data[lss_pkg::MODE_W-1:0];
                        r_pos  <= (i_cfg_data[lss_pkg::MODE_W-1:0] == lss_pkg::MODE_CHASE_RL)
                                  ? POS_W'(MAX_POS) : '0;
                        r_dir  <= 1'b1;
                    end
                    lss_pkg::CFG_SPEED: begin
                        r_interval <= interval_of(i_cfg_data[lss_pkg::SPEED_W-1:0]);
                    end
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_skip <= (i_in.elapsed_time == '0) || (r_mode == lss_pkg::MODE_STATIC);
            r_work <= {i_in.elapsed_time, 8'(r_interval >> 1)};
            r_rem  <= '0;
            r_smod <= '0;
            r_cnt  <= '0;
        end else if (r_state == lss_pkg::ST_DIV) begin
            r_work <= {r_work[DIV_W-2:0], w_qbit};
            r_rem  <= w_qbit ? REM_W'(w_trial - {1'b0, r_interval}) : REM_W'(w_trial);
            r_smod <= POS_W'(w_mod_trial);
            r_cnt  <= r_cnt + lss_pkg::CNT_W'(1);
        end
        if (w_load) begin
            r_opos <= lss_pkg::POS_OUT_W'(n_pos);
            r_odir <= n_dir;
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.position  = r_opos;
    assign o_out.moving_up = r_odir;

`ifndef SYNTH
    a_pos_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(SPAN - 1) || r_pos == POS_W'(SPAN - 1))
        else $error("position left the span");

    a_turn_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_dir) |-> r_pos == POS_W'(MAX_POS))
        else $error("ping-pong turned down away from the top end");

    a_result_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == lss_pkg::ST_APPLY)
        else $error("result appeared without a position update");
`endif

endmodule
